// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tppp_pkg.sv
package tppp_pkg;

  localparam int MAP_BITS_DEF = 6;
  localparam logic [31:0] HALF_TILE = 32'h0000_8000;
  localparam logic [31:0] OBJ_SIZE = 32'h0000_2000;
  localparam logic signed [31:0] ONE_TILE = 32'sh0001_0000;
  localparam logic signed [31:0] REACH_LAT = 32'sh0000_8000;

  localparam int CQ_W = 17;   // column quotient bits
  localparam int HQ_W = 15;   // height quotient bits
  localparam int ND = CQ_W;   // divide steps

  typedef enum logic [2:0] {
    REG_VIEW_POS_X   = 3'd0,
    REG_VIEW_POS_Y   = 3'd1,
    REG_VIEW_SINE    = 3'd2,
    REG_VIEW_COSINE  = 3'd3,
    REG_SCREEN_SCALE = 3'd4,
    REG_SCREEN_CTR   = 3'd5,
    REG_HEIGHT_NUMER = 3'd6,
    REG_NEAR_LIMIT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0]     crem;
    logic [CQ_W-1:0] clow;
    logic [CQ_W-1:0] cq;
    logic [30:0]     cdiv;
    logic            covf;
    logic            cneg;
    logic            czero;
    logic [22:0]     hrem;
    logic [HQ_W-1:0] hlow;
    logic [HQ_W-1:0] hq;
    logic [22:0]     hdiv;
    logic            hovf;
    logic            vis;
    logic            reach;
  } div_t;

  // 16.16 value times sign-magnitude 16-bit fraction
  function automatic logic [31:0] frac_mul(logic [31:0] a, logic [16:0] b);
    logic [31:0] mag;
    logic [47:0] p;
    logic [31:0] r;
    logic        neg;
    neg = b[16] ^ a[31];
    mag = a[31] ? (32'd0 - a) : a;
    p = 48'(mag) * 48'(b[15:0]);
    r = p[47:16];
    return neg ? (32'd0 - r) : r;
  endfunction

  // one restoring step of the column divider, and of the height divider when do_h is set
  function automatic div_t div_step(div_t d, logic do_h);
    div_t        r;
    logic [31:0] ct;
    logic [23:0] ht;
    r = d;
    ct = {d.crem, d.clow[CQ_W-1]};
    if (ct >= {1'b0, d.cdiv}) begin
      r.crem = 31'(ct - {1'b0, d.cdiv});
      r.cq = {d.cq[CQ_W-2:0], 1'b1};
    end else begin
      r.crem = ct[30:0];
      r.cq = {d.cq[CQ_W-2:0], 1'b0};
    end
    r.clow = {d.clow[CQ_W-2:0], 1'b0};
    if (do_h) begin
      ht = {d.hrem, d.hlow[HQ_W-1]};
      if (ht >= {1'b0, d.hdiv}) begin
        r.hrem = 23'(ht - {1'b0, d.hdiv});
        r.hq = {d.hq[HQ_W-2:0], 1'b1};
      end else begin
        r.hrem = ht[22:0];
        r.hq = {d.hq[HQ_W-2:0], 1'b0};
      end
      r.hlow = {d.hlow[HQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: src/tile_point_perspective_projection_unit.sv
// Throughput: one request per cycle; each of the 24 stages has its own valid and the
// stall chain lets bubbles close up, so a held result blocks intake only once all are full.
// The 17-step column divider sets the depth (one quotient bit per stage); the 15-step
// height divider runs beside it. Reset: synchronous, active high; clears all stage
// valids and loads register defaults.
module tile_point_perspective_projection_unit import tppp_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF,
  localparam int InW = ((2 * MAP_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [InW-1:0] s_tdata,   // tile_x, tile_y
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,   // screen_x[15:0], view_height[31:16], visible, in_reach
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int StD0 = 5;
  localparam int NS = StD0 + ND + 2;

  logic [31:0] view_pos_x, view_pos_y;
  logic [16:0] view_sine, view_cosine;
  logic [30:0] screen_scale, height_numer, near_limit;
  logic [15:0] screen_centre;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_pos_x <= '0;
      view_pos_y <= '0;
      view_sine <= '0;
      view_cosine <= 17'd65535;
      screen_scale <= '0;
      screen_centre <= '0;
      height_numer <= '0;
      near_limit <= 31'd22936;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_POS_X:   view_pos_x <= cfg_data;
        REG_VIEW_POS_Y:   view_pos_y <= cfg_data;
        REG_VIEW_SINE:    view_sine <= cfg_data[16:0];
        REG_VIEW_COSINE:  view_cosine <= cfg_data[16:0];
        REG_SCREEN_SCALE: screen_scale <= cfg_data[30:0];
        REG_SCREEN_CTR:   screen_centre <= cfg_data[15:0];
        REG_HEIGHT_NUMER: height_numer <= cfg_data[30:0];
        REG_NEAR_LIMIT:   near_limit <= cfg_data[30:0];
      endcase
    end
  end

  // stage valids and load enables
  logic [NS-1:0] vld, ld;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign s_tready = ld[0];
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: tile centre minus view position
  logic [31:0] tx_w, ty_w, gx_c, gy_c, gx, gy;
  assign tx_w = 32'(s_tdata[MAP_BITS-1:0]);
  assign ty_w = 32'(s_tdata[2*MAP_BITS-1:MAP_BITS]);
  assign gx_c = (tx_w << 16) + HALF_TILE - view_pos_x;
  assign gy_c = (ty_w << 16) + HALF_TILE - view_pos_y;

  // stage 2: rotation products
  logic [31:0] fcx, fsy, fcy, fsx;

  // stage 3: depth, lateral, visibility
  logic signed [31:0] nx_c, ny_c, nx3, ny3;
  logic vis_c, reach_c, vis3, reach3;
  assign nx_c = $signed(fcx - fsy - OBJ_SIZE);
  assign ny_c = $signed(fcy + fsx);
  assign vis_c = nx_c >= $signed({1'b0, near_limit});
  assign reach_c = vis_c && (nx_c < ONE_TILE) && (ny_c > -REACH_LAT) && (ny_c < REACH_LAT);

  // stage 4: column numerator
  logic signed [63:0] num_c, num4;
  logic [30:0] nx4;
  logic vis4, reach4;
  assign num_c = ny3 * $signed({1'b0, screen_scale});

  // stage 5: magnitude and height divider setup
  logic [62:0] mag5;
  logic [30:0] nx5;
  logic neg5, zero5, vis5, reach5, hovf5;
  logic [22:0] div8_5;
  logic [22:0] div8_c;
  assign div8_c = nx4[30:8];

  // divider pipeline
  div_t dv [0:ND];
  div_t d0_c;
  div_t dstep [1:ND];

  always_comb begin
    d0_c.cdiv = nx5;
    d0_c.covf = (nx5 == '0) ? !zero5 : (mag5[62:17] >= 46'(nx5));
    d0_c.cneg = neg5;
    d0_c.czero = zero5;
    d0_c.crem = mag5[47:17];
    d0_c.clow = mag5[16:0];
    d0_c.cq = '0;
    d0_c.hdiv = div8_5;
    d0_c.hovf = hovf5;
    d0_c.hrem = 23'(height_numer[30:15]);
    d0_c.hlow = height_numer[14:0];
    d0_c.hq = '0;
    d0_c.vis = vis5;
    d0_c.reach = reach5;
  end

  for (genvar k = 1; k <= ND; k++) begin : g_step
    assign dstep[k] = div_step(dv[k-1], (k <= HQ_W) ? 1'b1 : 1'b0);
  end

  // output formatting
  div_t df;
  logic signed [17:0] q;
  logic signed [18:0] sxw;
  logic [15:0] sx, ht;
  logic [39:0] out_next;

  assign df = dv[ND];

  always_comb begin
    priority if (df.czero) begin
      q = 18'sd0;
    end else if (df.covf) begin
      q = df.cneg ? -18'sd32768 : 18'sd32767;
    end else if (df.cneg) begin
      q = (df.cq > 17'd32768) ? -18'sd32768 : -$signed({1'b0, df.cq});
    end else begin
      q = (df.cq > 17'd32767) ? 18'sd32767 : $signed({1'b0, df.cq});
    end
    sxw = $signed({3'b000, screen_centre}) + $signed({q[17], q});
    priority if (sxw > 19'sd32767) sx = 16'h7FFF;
    else if (sxw < -19'sd32768) sx = 16'h8000;
    else sx = sxw[15:0];
    ht = df.hovf ? 16'h7FFF : {1'b0, df.hq};
    if (df.vis) out_next = {6'd0, df.reach, 1'b1, ht, sx};
    else out_next = '0;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      gx <= gx_c;
      gy <= gy_c;
    end
    if (ld[1]) begin
      fcx <= frac_mul(gx, view_cosine);
      fsy <= frac_mul(gy, view_sine);
      fcy <= frac_mul(gy, view_cosine);
      fsx <= frac_mul(gx, view_sine);
    end
    if (ld[2]) begin
      nx3 <= nx_c;
      ny3 <= ny_c;
      vis3 <= vis_c;
      reach3 <= reach_c;
    end
    if (ld[3]) begin
      num4 <= num_c;
      nx4 <= nx3[30:0];
      vis4 <= vis3;
      reach4 <= reach3;
    end
    if (ld[4]) begin
      mag5 <= num4[63] ? 63'(-num4) : num4[62:0];
      neg5 <= num4[63];
      zero5 <= (num4 == '0);
      nx5 <= nx4;
      div8_5 <= div8_c;
      hovf5 <= 23'(height_numer[30:15]) >= div8_c;
      vis5 <= vis4;
      reach5 <= reach4;
    end
    if (ld[StD0]) dv[0] <= d0_c;
    for (int k = 1; k <= ND; k++) begin
      if (ld[StD0+k]) dv[k] <= dstep[k];
    end
    if (ld[NS-1]) m_tdata <= out_next;
  end

endmodule

// File: src/tppp_checker.sv
`include "assert_macros.svh"

module tppp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `ASSERT_CLK_NR(a_rst_empty, clk, rst |=> !m_tvalid, "result valid right after reset")
  `ASSERT_CLK(a_hidden_zero, clk, rst, m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33], "hidden point has nonzero fields")
  `ASSERT_CLK(a_reach_vis, clk, rst, m_tvalid && m_tdata[33] |-> m_tdata[32], "in reach without visible")

endmodule

bind tile_point_perspective_projection_unit tppp_checker u_tppp_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// File: sim/tile_point_projection_checker.sv
`timescale 1ns / 100ps
module tile_point_projection_checker import tppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] h;
    logic        vis;
    logic        reach;
  } proj_t;

  logic [31:0] pos_x, pos_y;
  logic [16:0] sine, cosine;
  logic [30:0] scale, numer, near;
  logic [15:0] centre;
  proj_t       proj_q[$];

  function automatic logic [31:0] frac_scale(logic [31:0] v, logic [16:0] f);
    logic [31:0] m;
    logic [63:0] p;
    logic [31:0] r;
    logic        n;
    n = f[16];
    m = v;
    if (v[31]) begin
      m = 32'd0 - v;
      n = !n;
    end
    p = 64'(m) * 64'(f[15:0]);
    r = p[47:16];
    return n ? (32'd0 - r) : r;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic proj_t project(logic [5:0] tx, logic [5:0] ty);
    logic [31:0] gx, gy, nxu, nyu;
    longint      nx, ny, num, q, d8;
    proj_t       r;
    gx = {10'd0, tx, 16'd0} + HALF_TILE - pos_x;
    gy = {10'd0, ty, 16'd0} + HALF_TILE - pos_y;
    nxu = frac_scale(gx, cosine) - frac_scale(gy, sine) - OBJ_SIZE;
    nyu = frac_scale(gy, cosine) + frac_scale(gx, sine);
    nx = longint'($signed(nxu));
    ny = longint'($signed(nyu));
    r = '0;
    if (nx >= longint'(near)) begin
      num = ny * longint'(scale);
      d8 = nx >>> 8;
      if (nx == 0) q = (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
      else q = clip16(num / nx);
      r.sx = 16'(clip16(longint'(centre) + q));
      r.h = (d8 == 0) ? 16'd32767 : 16'(clip16(longint'(numer) / d8));
      r.vis = 1'b1;
      r.reach = (nx < 65536) && (ny > -32768) && (ny < 32768);
    end
    return r;
  endfunction

  task automatic mismatch(string field, logic [15:0] e, logic [15:0] a);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, e, a);
    fails++;
  endtask

  assign pending = proj_q.size();

  initial fails = 0;

  always @(posedge clk) begin
    proj_t e, g;
    if (rst) begin
      pos_x <= '0; pos_y <= '0; sine <= '0; cosine <= 17'd65535;
      scale <= '0; centre <= '0; numer <= '0; near <= 31'd22936;
      proj_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VIEW_POS_X:   pos_x <= cfg_data;
          REG_VIEW_POS_Y:   pos_y <= cfg_data;
          REG_VIEW_SINE:    sine <= cfg_data[16:0];
          REG_VIEW_COSINE:  cosine <= cfg_data[16:0];
          REG_SCREEN_SCALE: scale <= cfg_data[30:0];
          REG_SCREEN_CTR:   centre <= cfg_data[15:0];
          REG_HEIGHT_NUMER: numer <= cfg_data[30:0];
          REG_NEAR_LIMIT:   near <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) proj_q.push_back(project(s_tdata[5:0], s_tdata[11:6]));
      if (m_tvalid && m_tready) begin
        g = '{m_tdata[15:0], m_tdata[31:16], m_tdata[32], m_tdata[33]};
        if (proj_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, g);
          fails++;
        end else begin
          e = proj_q.pop_front();
          if (g.sx !== e.sx) mismatch("screen_x", e.sx, g.sx);
          if (g.h !== e.h) mismatch("view_height", e.h, g.h);
          if (g.vis !== e.vis) mismatch("visible", 16'(e.vis), 16'(g.vis));
          if (g.reach !== e.reach) mismatch("in_reach", 16'(e.reach), 16'(g.reach));
        end
      end
    end
  end

endmodule

// File: sim/tile_point_perspective_projection_unit_tb.sv
`timescale 1ns / 100ps
module tile_point_perspective_projection_unit_tb import tppp_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fails, pending, cycles = 0;
  int          rx_hold = 0;
  bit          tx_calm = 1'b0, rx_calm = 1'b0;
  logic [5:0]  view_tx, view_ty;

  tile_point_perspective_projection_unit u_top (.*);

  tile_point_projection_checker u_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (m_tvalid && m_tready) rx_hold = rx_calm ? 0 : $urandom_range(0, 10);

  always @(negedge clk)
    if (rst) m_tready = 1'b0;
    else if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else m_tready = 1'b1;

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // valid stays high after an accept so that requests can follow back to back
  task automatic send_tile(logic [5:0] tx, logic [5:0] ty);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'd0, ty, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic set_view(logic [31:0] px, logic [31:0] py, logic [16:0] sn, logic [16:0] cs,
                          logic [30:0] sc, logic [15:0] ctr, logic [30:0] hn, logic [30:0] nl);
    drain();
    write_reg(REG_VIEW_POS_X, px);
    write_reg(REG_VIEW_POS_Y, py);
    write_reg(REG_VIEW_SINE, {15'd0, sn});
    write_reg(REG_VIEW_COSINE, {15'd0, cs});
    write_reg(REG_SCREEN_SCALE, {1'b0, sc});
    write_reg(REG_SCREEN_CTR, {16'd0, ctr});
    write_reg(REG_HEIGHT_NUMER, {1'b0, hn});
    write_reg(REG_NEAR_LIMIT, {1'b0, nl});
  endtask

  function automatic logic [5:0] near_tile(logic [5:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return 6'(v);
  endfunction

  function automatic logic [30:0] rand31();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 255));
      1: return 31'($urandom_range(0, 65535) << 4);
      2: return 31'h7FFF_FFFF;
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // defaults after reset: corners and edges
    send_tile(6'd0, 6'd0);
    send_tile(6'd63, 6'd63);
    send_tile(6'd63, 6'd0);
    send_tile(6'd0, 6'd63);
    send_tile(6'd0, 6'd1);

    // depth exactly zero and below one height step, near limit off
    set_view(32'h0000_5FFF, 32'h0000_8000, 17'd0, 17'hFFFF, 31'h7FFF_FFFF, 16'd160,
             31'h7FFF_FFFF, 31'd0);
    send_tile(6'd0, 6'd0);
    send_tile(6'd0, 6'd5);
    set_view(32'h0000_5FFF, 32'h0008_8000, 17'd0, 17'hFFFF, 31'h7FFF_FFFF, 16'd160,
             31'h7FFF_FFFF, 31'd0);
    send_tile(6'd0, 6'd0);
    set_view(32'h0000_5FFE, 32'h0000_4000, 17'd0, 17'hFFFF, 31'd1000, 16'hFFFF,
             31'd12345, 31'd0);
    send_tile(6'd0, 6'd0);
    send_tile(6'd0, 6'd3);

    // extremes: negative fractions, corner view positions
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 31'h7FFF_FFFF, 16'hFFFF,
             31'h7FFF_FFFF, 31'd0);
    send_tile(6'd0, 6'd63);
    send_tile(6'd63, 6'd0);
    send_tile(6'd63, 6'd63);
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 17'h0FFFF, 17'h10000, 31'd0, 16'd0, 31'd0,
             31'h7FFF_FFFF);
    send_tile(6'd0, 6'd0);
    send_tile(6'd63, 6'd63);
    set_view(32'h0010_0000, 32'h0010_0000, 17'd0, 17'hFFFF, 31'h0010_0000, 16'd320,
             31'h0040_0000, 31'd0);
    send_tile(6'd16, 6'd16);
    send_tile(6'd17, 6'd16);
    send_tile(6'd15, 6'd16);
    send_tile(6'd16, 6'd17);

    for (int ph = 0; ph < 14; ph++) begin
      logic [31:0] px, py;
      tx_calm = (ph % 4 == 1);
      rx_calm = (ph % 4 == 2);
      view_tx = 6'($urandom);
      view_ty = 6'($urandom);
      px = ($urandom_range(0, 3) == 0) ? $urandom : {10'd0, view_tx, 16'($urandom)};
      py = ($urandom_range(0, 3) == 0) ? $urandom : {10'd0, view_ty, 16'($urandom)};
      set_view(px, py, 17'($urandom), 17'($urandom), rand31(), 16'($urandom), rand31(),
               ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom_range(0, 65535)));
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 1)) send_tile(near_tile(view_tx), near_tile(view_ty));
        else send_tile(6'($urandom), 6'($urandom));
      end
    end

    drain();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
